// ===== sv/jeo_pkg.sv =====
package jeo_pkg;

  // Width of a person number, of the circle size and of the step count.
  localparam int PERSON_W = 7;

  // Default circle capacity.
  localparam int MAX_PEOPLE_DEF = 64;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PEOPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 1'b1;

endpackage

// ===== sv/jeo_if.sv =====
// Start channel: one item carries the go flag.
interface jeo_req_if;
  logic valid;
  logic ready;
  logic go;

  modport source (output valid, output go, input ready);
  modport sink (input valid, input go, output ready);
endinterface

// Result channel: one item per removed person.
interface jeo_res_if import jeo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERSON_W-1:0] person;
  logic                final_res;

  modport source (output valid, output person, output final_res, input ready);
  modport sink (input valid, input person, input final_res, output ready);
endinterface

// Configuration write channel.
interface jeo_cfg_if import jeo_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PERSON_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/josephus_elimination_order_core.sv =====
// Channel | Dir | Payload               | Accepted when
// cfg     | in  | index, data           | cfg.valid && cfg.ready (always ready)
// req     | in  | go                    | req.valid && req.ready
// res     | out | person, final_res     | res.valid && res.ready
//
// A start item with go set first loads the circle, then each queue step reads
// the memory, then decides and writes back, and each removal adds a state in
// which the result is offered. A run of n people with step k makes (n-1)*k + 1
// queue steps, and the single memory read port is read once per queue step.
// An item with go clear is taken and causes nothing. Reset is synchronous and
// clears the sequencer and the configuration to one; the circle memory is
// written by each run before it is read and has no reset. req.ready is low for
// the whole run, and the sequencer holds while a result waits on res.ready.
module josephus_elimination_order_core
  import jeo_pkg::*;
#(
  parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
  input  logic clk,
  input  logic rst,
  jeo_cfg_if.sink   cfg,
  jeo_req_if.sink   req,
  jeo_res_if.source res
);

  localparam int PTR_W = $clog2(MAX_PEOPLE);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILL   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  localparam logic [PERSON_W-1:0] ONE     = PERSON_W'(1);
  localparam logic [PERSON_W-1:0] CAP     = PERSON_W'(MAX_PEOPLE);
  localparam logic [PTR_W-1:0]    LAST_SL = PTR_W'(MAX_PEOPLE - 1);

  logic [2:0]          state;
  logic [PERSON_W-1:0] people_count;
  logic [PERSON_W-1:0] step_size;
  logic [PERSON_W-1:0] n_run;
  logic [PERSON_W-1:0] k_run;
  logic [PTR_W-1:0]    fill_idx;
  logic [PTR_W-1:0]    head_ptr;
  logic [PTR_W-1:0]    tail_ptr;
  logic [PERSON_W-1:0] remaining;
  logic [PERSON_W-1:0] position_count;
  logic [PERSON_W-1:0] out_person;
  logic                out_final;

  logic [PERSON_W-1:0] ring_store [MAX_PEOPLE];
  logic [PERSON_W-1:0] rd_data;
  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;
  logic [PERSON_W-1:0] mem_wdata;
  logic [PERSON_W-1:0] n_clamped;
  logic [PERSON_W-1:0] k_clamped;
  logic                is_rotate;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST_SL) ? '0 : p + PTR_W'(1);
  endfunction

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      people_count <= ONE;
      step_size    <= ONE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PEOPLE_COUNT: people_count <= cfg.data;
        REG_STEP_SIZE:    step_size    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamp the circle size to 1..MAX_PEOPLE and the step to at least one.
  always_comb begin
    if (people_count == '0) begin
      n_clamped = ONE;
    end else if (people_count > CAP) begin
      n_clamped = CAP;
    end else begin
      n_clamped = people_count;
    end
    k_clamped = (step_size == '0) ? ONE : step_size;
  end

  // The front person goes to the back unless removed or the sole survivor.
  assign is_rotate = (remaining != ONE) && (position_count != k_run);

  // Circle memory: one write port, one registered read port at the head.
  always_comb begin
    mem_we    = (state == ST_FILL) || ((state == ST_DECIDE) && is_rotate);
    mem_waddr = (state == ST_FILL) ? fill_idx : tail_ptr;
    mem_wdata = (state == ST_FILL) ? PERSON_W'(fill_idx) + ONE : rd_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_store[mem_waddr] <= mem_wdata;
    end
    rd_data <= ring_store[head_ptr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head_ptr       <= '0;
      tail_ptr       <= '0;
      remaining      <= '0;
      position_count <= ONE;
      fill_idx       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid && req.go) begin
            n_run          <= n_clamped;
            k_run          <= k_clamped;
            fill_idx       <= '0;
            head_ptr       <= '0;
            tail_ptr       <= (n_clamped >= CAP) ? '0 : n_clamped[PTR_W-1:0];
            remaining      <= n_clamped;
            position_count <= ONE;
            state          <= ST_FILL;
          end
        end
        ST_FILL: begin
          fill_idx <= fill_idx + PTR_W'(1);
          if (PERSON_W'(fill_idx) == n_run - ONE) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          head_ptr <= next_slot(head_ptr);
          if (remaining == ONE) begin
            out_person <= rd_data;
            out_final  <= 1'b1;
            remaining  <= '0;
            state      <= ST_OUT;
          end else if (position_count == k_run) begin
            out_person     <= rd_data;
            out_final      <= 1'b0;
            remaining      <= remaining - ONE;
            position_count <= ONE;
            state          <= ST_OUT;
          end else begin
            tail_ptr       <= next_slot(tail_ptr);
            position_count <= position_count + ONE;
            state          <= ST_READ;
          end
        end
        ST_OUT: begin
          if (res.ready) begin
            state <= (remaining == '0) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready     = (state == ST_IDLE);
  assign res.valid     = (state == ST_OUT);
  assign res.person    = out_person;
  assign res.final_res = out_final;

endmodule

// ===== sv/jeo_checker.sv =====
module jeo_checker
  import jeo_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                req_go,
  input logic                res_valid,
  input logic                res_ready,
  input logic [PERSON_W-1:0] res_person,
  input logic                res_final_res
);

  // A result that is not taken stays offered unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_person) &&
                                $stable(res_final_res))
    else $error("result changed while stalled");

  // The block never takes a start item while a result is pending.
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid))
    else $error("start channel ready while a result is pending");

  // A start item with go set makes the block busy at once.
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_go |=> !req_ready)
    else $error("still ready after a start item");

  // Person numbers start at one.
  a_person_nz: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_person != '0)
    else $error("person number zero");

  // Once the last person is taken, the block is ready for a new run.
  a_end_ready: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_final_res |=> req_ready && !res_valid)
    else $error("not idle after the last person");

endmodule

bind josephus_elimination_order_core jeo_checker u_jeo_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_go        (req.go),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_person    (res.person),
  .res_final_res (res.final_res)
);
